@@ src/jsu_pkg.sv @@
// shared types, codes and utf-8 helpers for the json string unescaper
package jsu_pkg;

  localparam int JSU_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CTRL_MAX  = 8'h1F;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [20:0] ONE_MAX     = 21'h7F;
  localparam logic [20:0] TWO_MAX     = 21'h7FF;
  localparam logic [20:0] THREE_MAX   = 21'hFFFF;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_STR   = 3'd1,
    PH_ESC   = 3'd2,
    PH_HEX1  = 3'd3,
    PH_AFTHI = 3'd4,
    PH_HIESC = 3'd5,
    PH_HEX2  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NO_QUOTE   = 3'd0,
    ERR_UNTERM     = 3'd1,
    ERR_NO_ESC     = 3'd2,
    ERR_BAD_ESC    = 3'd3,
    ERR_SHORT_HEX  = 3'd4,
    ERR_NOT_HEX    = 3'd5,
    ERR_CONTROL    = 3'd6
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } text_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [2:0] err_code;
    logic       last;
  } result_t;

  // one accepted request worth of output: up to two code points, then a tail
  typedef struct packed {
    logic [20:0] cp0;
    logic [2:0]  len0;
    logic [15:0] cp1;
    logic [1:0]  len1;
    logic        tail_en;
    kind_t       tail_kind;
    logic [7:0]  tail_byte;
    err_t        tail_err;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= ONE_MAX) begin
      n = 3'd1;
    end else if (cp <= TWO_MAX) begin
      n = 3'd2;
    end else if (cp <= THREE_MAX) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = {2'b10, cp[5:0]};
    unique case (len)
      3'd1: r = cp[7:0];
      3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

@@ src/jsu_front.sv @@
// front end: string parsing state machine, turns each request into a job
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  jsu_pkg::text_t item,
  output logic          push,
  output jsu_pkg::job_t job
);
  import jsu_pkg::*;

  typedef struct packed {
    phase_t     phase;
    logic       tail_en;
    kind_t      kind;
    logic [7:0] tbyte;
    err_t       err;
    logic       hex_start;
  } act_t;

  phase_t      phase, phase_next;
  logic [15:0] hex_value, hex_value_next;
  logic [1:0]  hex_digits, hex_digits_next;
  logic        hex_bad, hex_bad_next;
  logic [15:0] high_half, high_half_next;

  logic [7:0]  b;
  logic        is_end;
  act_t        sb, eb, act;
  logic [7:0]  esc_map;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] hex_shift;
  logic        bad_all;
  logic        hex_last;
  logic [20:0] cp0;
  logic        cp0_en;
  logic [15:0] cp1;
  logic        cp1_en;
  logic [20:0] pair_cp;

  assign b      = item.in_byte;
  assign is_end = item.in_end;

  // action for a plain string byte
  always_comb begin
    sb = '{phase: PH_STR, tail_en: 1'b1, kind: KIND_DATA, tbyte: b, err: ERR_NO_QUOTE,
           hex_start: 1'b0};
    if (b == CH_QUOTE) begin
      sb.phase = PH_IDLE;
      sb.kind  = KIND_DONE;
      sb.tbyte = '0;
    end else if (b == CH_BSLASH) begin
      sb.phase   = PH_ESC;
      sb.tail_en = 1'b0;
    end else if (b <= CTRL_MAX) begin
      sb.phase = PH_IDLE;
      sb.kind  = KIND_ERROR;
      sb.tbyte = '0;
      sb.err   = ERR_CONTROL;
    end
  end

  // action for the byte after a backslash
  always_comb begin
    unique case (b)
      CH_QUOTE:  esc_map = CH_QUOTE;
      CH_BSLASH: esc_map = CH_BSLASH;
      CH_SLASH:  esc_map = CH_SLASH;
      8'h62:     esc_map = 8'h08;
      8'h66:     esc_map = 8'h0C;
      8'h6E:     esc_map = 8'h0A;
      8'h72:     esc_map = 8'h0D;
      8'h74:     esc_map = 8'h09;
      default:   esc_map = 8'h00;
    endcase
    eb = '{phase: PH_STR, tail_en: 1'b1, kind: KIND_DATA, tbyte: esc_map, err: ERR_NO_QUOTE,
           hex_start: 1'b0};
    if (esc_map == 8'h00) begin
      if (b == CH_LOW_U) begin
        eb.phase     = PH_HEX1;
        eb.tail_en   = 1'b0;
        eb.hex_start = 1'b1;
      end else begin
        eb.phase = PH_IDLE;
        eb.kind  = KIND_ERROR;
        eb.err   = ERR_BAD_ESC;
      end
    end
  end

  // hex digit decode
  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      digit = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      digit = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      digit = 4'(b - 8'h57);
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign hex_shift = {hex_value[11:0], digit};
  assign bad_all   = hex_bad | ~digit_ok;
  assign hex_last  = (hex_digits == 2'd3);
  assign pair_cp   = SUPP_BASE + {1'b0, high_half[9:0], hex_shift[9:0]};

  always_comb begin
    phase_next      = phase;
    hex_value_next  = hex_value;
    hex_digits_next = hex_digits;
    hex_bad_next    = hex_bad;
    high_half_next  = high_half;
    cp0    = '0;
    cp0_en = 1'b0;
    cp1    = '0;
    cp1_en = 1'b0;
    act = '{phase: PH_IDLE, tail_en: 1'b0, kind: KIND_DATA, tbyte: '0, err: ERR_NO_QUOTE,
            hex_start: 1'b0};

    unique case (phase)
      PH_STR: begin
        if (is_end) begin
          act = '{phase: PH_IDLE, tail_en: 1'b1, kind: KIND_ERROR, tbyte: '0,
                  err: ERR_UNTERM, hex_start: 1'b0};
        end else begin
          act = sb;
        end
      end
      PH_ESC: begin
        if (is_end) begin
          act = '{phase: PH_IDLE, tail_en: 1'b1, kind: KIND_ERROR, tbyte: '0,
                  err: ERR_NO_ESC, hex_start: 1'b0};
        end else begin
          act = eb;
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (is_end) begin
          act = '{phase: PH_IDLE, tail_en: 1'b1, kind: KIND_ERROR, tbyte: '0,
                  err: ERR_SHORT_HEX, hex_start: 1'b0};
        end else begin
          hex_value_next  = hex_shift;
          hex_bad_next    = bad_all;
          hex_digits_next = hex_last ? 2'd0 : 2'(hex_digits + 2'd1);
          act.phase       = phase;
          if (hex_last) begin
            if (bad_all) begin
              act = '{phase: PH_IDLE, tail_en: 1'b1, kind: KIND_ERROR, tbyte: '0,
                      err: ERR_NOT_HEX, hex_start: 1'b0};
            end else if (phase == PH_HEX1) begin
              if (hex_shift >= HI_SURR_MIN && hex_shift <= HI_SURR_MAX) begin
                high_half_next = hex_shift;
                act.phase      = PH_AFTHI;
              end else begin
                cp0       = {5'b0, hex_shift};
                cp0_en    = 1'b1;
                act.phase = PH_STR;
              end
            end else begin
              act.phase = PH_STR;
              cp0_en    = 1'b1;
              if (hex_shift >= LO_SURR_MIN && hex_shift <= LO_SURR_MAX) begin
                cp0 = pair_cp;
              end else begin
                cp0    = {5'b0, high_half};
                cp1    = hex_shift;
                cp1_en = 1'b1;
              end
            end
          end
        end
      end
      PH_AFTHI: begin
        if (is_end) begin
          cp0    = {5'b0, high_half};
          cp0_en = 1'b1;
          act = '{phase: PH_IDLE, tail_en: 1'b1, kind: KIND_ERROR, tbyte: '0,
                  err: ERR_UNTERM, hex_start: 1'b0};
        end else if (b == CH_BSLASH) begin
          act.phase = PH_HIESC;
        end else begin
          cp0    = {5'b0, high_half};
          cp0_en = 1'b1;
          act    = sb;
        end
      end
      PH_HIESC: begin
        if (is_end) begin
          cp0    = {5'b0, high_half};
          cp0_en = 1'b1;
          act = '{phase: PH_IDLE, tail_en: 1'b1, kind: KIND_ERROR, tbyte: '0,
                  err: ERR_NO_ESC, hex_start: 1'b0};
        end else if (b == CH_LOW_U) begin
          act.phase     = PH_HEX2;
          act.hex_start = 1'b1;
        end else begin
          cp0    = {5'b0, high_half};
          cp0_en = 1'b1;
          act    = eb;
        end
      end
      default: begin
        if (!is_end && b == CH_QUOTE) begin
          act.phase = PH_STR;
        end else begin
          act = '{phase: PH_IDLE, tail_en: 1'b1, kind: KIND_ERROR, tbyte: '0,
                  err: ERR_NO_QUOTE, hex_start: 1'b0};
        end
      end
    endcase

    phase_next = act.phase;
    if (act.hex_start) begin
      hex_value_next  = '0;
      hex_digits_next = '0;
      hex_bad_next    = 1'b0;
    end

    job.cp0       = cp0;
    job.len0      = cp0_en ? utf8_len(cp0) : 3'd0;
    job.cp1       = cp1;
    job.len1      = cp1_en ? 2'(utf8_len({5'b0, cp1})) : 2'd0;
    job.tail_en   = act.tail_en;
    job.tail_kind = act.kind;
    job.tail_byte = act.tbyte;
    job.tail_err  = act.err;
  end

  assign push = accept && (cp0_en || cp1_en || act.tail_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hex_value  <= '0;
      hex_digits <= '0;
      hex_bad    <= 1'b0;
      high_half  <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      hex_value  <= hex_value_next;
      hex_digits <= hex_digits_next;
      hex_bad    <= hex_bad_next;
      high_half  <= high_half_next;
    end
  end

endmodule

@@ src/jsu_queue.sv @@
// small job queue between front and back
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::job_t wr_job,
  input  logic          pop,
  output jsu_pkg::job_t rd_job,
  output logic          empty,
  output logic          full
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;

  assign empty  = (count == '0);
  assign full   = (count == CNT_FULL);
  assign rd_job = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_LAST) ? '0 : PTR_W'(tail + 1'b1);
      end
      if (pop) begin
        head <= (head == PTR_LAST) ? '0 : PTR_W'(head + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

@@ src/jsu_back.sv @@
// back end: expands a job into result bytes, one per cycle unless res_stall holds the output register
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::job_t    head_job,
  input  logic             q_empty,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output jsu_pkg::result_t res
);
  import jsu_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [2:0] step;

  logic [3:0] total;
  logic       is_last;
  logic       can_emit;
  logic       emit;
  logic [2:0] rel;
  result_t    res_next;

  assign total    = {1'b0, cur.len0} + {2'b0, cur.len1} + {3'b0, cur.tail_en};
  assign is_last  = ({1'b0, step} == 4'(total - 4'd1));
  assign can_emit = !res_valid || !res_stall;
  assign emit     = cur_valid && can_emit;
  assign pop      = !q_empty && (!cur_valid || (emit && is_last));
  assign rel      = 3'(step - cur.len0);

  always_comb begin
    res_next = '{out_kind: KIND_DATA, out_byte: '0, err_code: '0, last: is_last};
    if (step < cur.len0) begin
      res_next.out_byte = utf8_byte(cur.cp0, cur.len0, step[1:0]);
    end else if (rel < {1'b0, cur.len1}) begin
      res_next.out_byte = utf8_byte({5'b0, cur.cp1}, {1'b0, cur.len1}, rel[1:0]);
    end else begin
      res_next.out_kind = cur.tail_kind;
      unique case (cur.tail_kind)
        KIND_DATA:  res_next.out_byte = cur.tail_byte;
        KIND_ERROR: res_next.err_code = cur.tail_err;
        default:    res_next.out_byte = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (emit) begin
        if (is_last) begin
          cur_valid <= 1'b0;
        end
        step <= 3'(step + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
    if (emit) begin
      res <= res_next;
    end
  end

endmodule

@@ src/json_string_unescape_utf8.sv @@
// top level of the json string unescaper with utf-8 output
//
//   channel  valid       stall       payload        direction
//   text     text_valid  text_stall  text (text_t)  request in, one raw byte or end mark
//   result   res_valid   res_stall   res (result_t) request out, decoded byte, done or error
//
// one text request per cycle is taken while the job queue has room
// a request yields zero to six results; the back end emits one result per cycle,
// except while res_stall holds the output register
// from text accept to first result, a job passes the queue slot, the back end's job register, then the output register
// reset: rst clears the parse state, queue pointers and output valid; no clearing pass
// text_stall rises only when the job queue is full; res_stall freezes the output register
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_stall,
  input  jsu_pkg::text_t   text,
  output logic             res_valid,
  input  logic             res_stall,
  output jsu_pkg::result_t res
);
  import jsu_pkg::*;

  logic  accept;
  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;
  job_t  front_job;
  job_t  head_job;

  // front only waits on queue space
  assign text_stall = q_full;
  assign accept     = text_valid && !q_full;

  // parse state machine, classifies each request into a job
  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (text),
    .push   (push),
    .job    (front_job)
  );

  // decouples parsing from result emission
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (front_job),
    .pop    (pop),
    .rd_job (head_job),
    .empty  (q_empty),
    .full   (q_full)
  );

  // utf-8 expansion and result output register
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_job  (head_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

`ifndef SYNTH
  // a job is never written into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("job pushed into full queue");

  // the back end only takes a job that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("pop from empty queue");

  // done and error end the request's results
  a_tail_last: assert property (@(posedge clk) disable iff (rst)
      res_valid && (res.out_kind == KIND_DONE || res.out_kind == KIND_ERROR) |-> res.last)
    else $error("done or error result without last");

  // only data results carry a byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
      res_valid && res.out_kind != KIND_DATA |-> res.out_byte == 8'h00)
    else $error("non-data result with nonzero byte");
`endif

endmodule

@@ dv/tb_json_string_unescape_utf8.sv @@
// self-checking testbench for the json string unescaper with utf-8 output
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  // last part of the run: no idling on either side
  localparam int QUIET_ITEMS = 60;
  localparam int TOTAL_ITEMS = 460;
  localparam int SETTLE_CYCLES = 20;
  // code field reads zero outside errors
  localparam err_t NO_ERR = ERR_NO_QUOTE;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    text_valid = 1'b0;
  logic    text_stall;
  text_t   text = '0;
  logic    res_valid;
  logic    res_stall = 1'b0;
  result_t res;

  json_string_unescape_utf8 dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  always #1 clk = ~clk;

  // a drain mark makes the sender hold off until every expected result is out
  typedef struct packed {
    logic  drain;
    text_t t;
  } text_req_t;

  text_req_t text_backlog[$];   // requests not yet offered
  result_t   step_results[$];   // results of the request being decoded
  result_t   decoded_due[$];    // decoded results still to come from the block

  int   fail_count = 0;
  int   send_gap = 0;
  int   hold_left = 0;
  logic text_fire = 1'b0;
  logic quiet_tail = 1'b0;

  // ---------------------------------------------------------------------------
  // decoder state mirrored in the testbench
  // ---------------------------------------------------------------------------
  phase_t      ph = PH_IDLE;
  logic [15:0] hex_acc = '0;
  logic [1:0]  hex_cnt = '0;
  logic        hex_bad = 1'b0;
  logic [15:0] surr_hi = '0;

  function automatic void emit(kind_t k, logic [7:0] b, err_t e);
    result_t r;
    r.out_kind = k;
    r.out_byte = b;
    r.err_code = e;
    r.last     = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void emit_data(logic [7:0] b);
    emit(KIND_DATA, b, NO_ERR);
  endfunction

  // an error ends the string and sends the decoder back to hunting for a quote
  function automatic void abort(err_t e);
    emit(KIND_ERROR, 8'h00, e);
    ph = PH_IDLE;
  endfunction

  function automatic void put_code_point(logic [20:0] cp);
    if (cp <= ONE_MAX) begin
      emit_data(cp[7:0]);
    end else if (cp <= TWO_MAX) begin
      emit_data({3'b110, cp[10:6]});
      emit_data({2'b10, cp[5:0]});
    end else if (cp <= THREE_MAX) begin
      emit_data({4'b1110, cp[15:12]});
      emit_data({2'b10, cp[11:6]});
      emit_data({2'b10, cp[5:0]});
    end else begin
      emit_data({5'b11110, cp[20:18]});
      emit_data({2'b10, cp[17:12]});
      emit_data({2'b10, cp[11:6]});
      emit_data({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic hex_nibble(input logic [7:0] b, output logic [3:0] v);
    logic ok;
    ok = 1'b1;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 4'(b - 8'h41 + 8'd10);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 4'(b - 8'h61 + 8'd10);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // shifts in one digit; true once four digits are in and all were hex
  function automatic logic hex_digit_in(logic [7:0] b);
    logic [3:0] v;
    logic       ok;
    ok = hex_nibble(b, v);
    hex_acc = {hex_acc[11:0], v};
    if (!ok) hex_bad = 1'b1;
    if (hex_cnt != 2'd3) begin
      hex_cnt = hex_cnt + 2'd1;
      return 1'b0;
    end
    hex_cnt = 2'd0;
    if (hex_bad) begin
      abort(ERR_NOT_HEX);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void hex_start(phase_t next);
    hex_acc = '0;
    hex_cnt = '0;
    hex_bad = 1'b0;
    ph = next;
  endfunction

  // ordinary text inside the quotes
  function automatic void plain_char(logic [7:0] b);
    if (b == CH_QUOTE) begin
      emit(KIND_DONE, 8'h00, NO_ERR);
      ph = PH_IDLE;
    end else if (b == CH_BSLASH) begin
      ph = PH_ESC;
    end else if (b <= CTRL_MAX) begin
      abort(ERR_CONTROL);
    end else begin
      emit_data(b);
      ph = PH_STR;
    end
  endfunction

  // character after a backslash
  function automatic void escape_char(logic [7:0] b);
    logic [7:0] mapped;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: mapped = b;
      8'h62:   mapped = 8'h08;  // b
      8'h66:   mapped = 8'h0C;  // f
      8'h6E:   mapped = 8'h0A;  // n
      8'h72:   mapped = 8'h0D;  // r
      8'h74:   mapped = 8'h09;  // t
      default: mapped = 8'h00;
    endcase
    if (mapped != 8'h00) begin
      emit_data(mapped);
      ph = PH_STR;
    end else if (b == CH_LOW_U) begin
      hex_start(PH_HEX1);
    end else begin
      abort(ERR_BAD_ESC);
    end
  endfunction

  // decodes one accepted request and queues the results it must produce
  function automatic void unescape_step(text_t t);
    logic [7:0] b;
    logic       fin;
    b = t.in_byte;
    fin = t.in_end;
    step_results.delete();
    case (ph)
      PH_STR: begin
        if (fin) abort(ERR_UNTERM);
        else plain_char(b);
      end
      PH_ESC: begin
        if (fin) abort(ERR_NO_ESC);
        else escape_char(b);
      end
      PH_HEX1: begin
        if (fin) begin
          abort(ERR_SHORT_HEX);
        end else if (hex_digit_in(b)) begin
          if (hex_acc >= HI_SURR_MIN && hex_acc <= HI_SURR_MAX) begin
            // hold the high half until we see what follows
            surr_hi = hex_acc;
            ph = PH_AFTHI;
          end else begin
            put_code_point({5'd0, hex_acc});
            ph = PH_STR;
          end
        end
      end
      PH_AFTHI: begin
        if (fin) begin
          put_code_point({5'd0, surr_hi});
          abort(ERR_UNTERM);
        end else if (b == CH_BSLASH) begin
          ph = PH_HIESC;
        end else begin
          // high half stands alone, byte is ordinary text
          put_code_point({5'd0, surr_hi});
          plain_char(b);
        end
      end
      PH_HIESC: begin
        if (fin) begin
          put_code_point({5'd0, surr_hi});
          abort(ERR_NO_ESC);
        end else if (b == CH_LOW_U) begin
          hex_start(PH_HEX2);
        end else begin
          put_code_point({5'd0, surr_hi});
          escape_char(b);
        end
      end
      PH_HEX2: begin
        if (fin) begin
          abort(ERR_SHORT_HEX);
        end else if (hex_digit_in(b)) begin
          if (hex_acc >= LO_SURR_MIN && hex_acc <= LO_SURR_MAX) begin
            put_code_point(SUPP_BASE + {1'b0, surr_hi[9:0], hex_acc[9:0]});
          end else begin
            // bad low half: both values go out on their own
            put_code_point({5'd0, surr_hi});
            put_code_point({5'd0, hex_acc});
          end
          ph = PH_STR;
        end
      end
      default: begin
        if (!fin && b == CH_QUOTE) ph = PH_STR;
        else abort(ERR_NO_QUOTE);
      end
    endcase
    if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) decoded_due.insert(decoded_due.size(), step_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b);
    text_req_t r;
    r.drain     = 1'b0;
    r.t.in_byte = b;
    r.t.in_end  = 1'b0;
    text_backlog.insert(text_backlog.size(), r);
  endfunction

  // byte lane carries junk with the end mark
  function automatic void put_end();
    text_req_t r;
    r.drain     = 1'b0;
    r.t.in_byte = 8'($urandom_range(0, 255));
    r.t.in_end  = 1'b1;
    text_backlog.insert(text_backlog.size(), r);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    logic [3:0] v;
    b = 8'($urandom_range(0, 255));
    while (hex_nibble(b, v)) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] esc_char(int i);
    case (i)
      0:       return CH_QUOTE;
      1:       return CH_BSLASH;
      2:       return CH_SLASH;
      3:       return 8'h62;
      4:       return 8'h66;
      5:       return 8'h6E;
      6:       return 8'h72;
      default: return 8'h74;
    endcase
  endfunction

  function automatic logic [7:0] bad_esc_char();
    logic [7:0] b;
    logic       hit;
    hit = 1'b1;
    b = 8'h00;
    while (hit) begin
      b = 8'($urandom_range(0, 255));
      hit = (b == CH_LOW_U);
      for (int i = 0; i < 8; i++) if (b == esc_char(i)) hit = 1'b1;
    end
    return b;
  endfunction

  function automatic void put_uescape(logic [15:0] v);
    put_byte(CH_BSLASH);
    put_byte(CH_LOW_U);
    for (int i = 0; i < 4; i++) put_byte(hex_char(4'(v >> (12 - 4 * i))));
  endfunction

  function automatic logic [15:0] rand_high();
    return HI_SURR_MIN + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] rand_low();
    return LO_SURR_MIN + 16'($urandom_range(0, 16'h3FF));
  endfunction

  // \u and up to three digits, some not hex, cut short by the end mark
  function automatic void put_short_hex();
    int n;
    n = $urandom_range(0, 3);
    put_byte(CH_BSLASH);
    put_byte(CH_LOW_U);
    for (int i = 0; i < n; i++)
      put_byte(($urandom_range(0, 3) == 0) ? non_hex_byte()
                                           : hex_char(4'($urandom_range(0, 15))));
    put_end();
  endfunction

  // one piece of string content; returns 1 when the piece ends the string
  function automatic logic put_fragment();
    int          pick;
    int          pos;
    logic [15:0] v;
    logic [7:0]  b;
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2, 3, 4, 5: begin
        b = 8'($urandom_range(8'h20, 8'hFF));
        if (b == CH_QUOTE || b == CH_BSLASH) b = 8'h7E;
        put_byte(b);
      end
      6, 7: begin
        put_byte(CH_BSLASH);
        put_byte(esc_char($urandom_range(0, 7)));
      end
      8:  put_uescape(16'($urandom_range(0, 16'h7F)));
      9:  put_uescape(16'($urandom_range(16'h80, 16'h7FF)));
      10: begin
        v = 16'($urandom_range(16'h800, 16'hFFFF));
        if (v >= HI_SURR_MIN && v <= LO_SURR_MAX) v = v ^ 16'h4000;
        put_uescape(v);
      end
      11, 12: begin
        put_uescape(rand_high());
        put_uescape(rand_low());
      end
      // high half then whatever the next piece brings
      13: put_uescape(rand_high());
      // high half then a non-u escape
      14: begin
        put_uescape(rand_high());
        put_byte(CH_BSLASH);
        if ($urandom_range(0, 3) == 0) begin
          put_byte(bad_esc_char());
          return 1'b1;
        end
        put_byte(esc_char($urandom_range(0, 7)));
      end
      // bad low half, possibly another high half
      15: begin
        put_uescape(rand_high());
        v = 16'($urandom_range(0, 16'hFFFF));
        if (v >= LO_SURR_MIN && v <= LO_SURR_MAX) v = v ^ 16'h2000;
        if ($urandom_range(0, 3) == 0) v = rand_high();
        put_uescape(v);
      end
      16: put_uescape(rand_low());
      // four digits with a non-hex among them
      17: begin
        if ($urandom_range(0, 1)) put_uescape(rand_high());
        pos = $urandom_range(0, 3);
        v = 16'($urandom_range(0, 16'hFFFF));
        put_byte(CH_BSLASH);
        put_byte(CH_LOW_U);
        for (int i = 0; i < 4; i++)
          put_byte((i == pos) ? non_hex_byte() : hex_char(4'(v >> (12 - 4 * i))));
        return 1'b1;
      end
      18: begin
        if ($urandom_range(0, 1)) begin
          put_byte(8'($urandom_range(0, CTRL_MAX)));
        end else begin
          put_byte(CH_BSLASH);
          put_byte(bad_esc_char());
        end
        return 1'b1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: begin
            put_byte(CH_BSLASH);
            put_end();
          end
          1: put_short_hex();
          2: begin
            put_uescape(rand_high());
            if ($urandom_range(0, 1)) put_byte(CH_BSLASH);
            put_end();
          end
          default: begin
            put_uescape(rand_high());
            put_short_hex();
          end
        endcase
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void put_string();
    int   n;
    logic over;
    put_byte(CH_QUOTE);
    n = $urandom_range(0, 6);
    over = 1'b0;
    for (int i = 0; i < n && !over; i++) over = put_fragment();
    if (!over) begin
      if ($urandom_range(0, 9) == 0) put_end();
      else put_byte(CH_QUOTE);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result check
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // text sender: new request at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (text_valid && !text_fire) begin
      // stalled, payload stays put
    end else if (send_gap != 0) begin
      send_gap = send_gap - 1;
      text_valid <= 1'b0;
    end else if (text_backlog.size() == 0 ||
                 (text_backlog[0].drain && decoded_due.size() != 0)) begin
      text_valid <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(0, 8);
      text_valid <= 1'b0;
    end else begin
      text <= text_backlog[0].t;
      text_valid <= 1'b1;
      void'(text_backlog.pop_front());
    end
  end

  // result receiver: random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      res_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 8);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // decode each accepted request, then compare each accepted result in order
  always @(posedge clk) begin : watch
    result_t want;
    text_fire <= !rst && text_valid && !text_stall;
    quiet_tail <= (text_backlog.size() < QUIET_ITEMS);
    if (!rst) begin
      if (text_valid && !text_stall) unescape_step(text);
      if (res_valid && !res_stall) begin
        if (decoded_due.size() == 0) begin
          $error("result with nothing expected: kind %0d byte %0h code %0d",
                 res.out_kind, res.out_byte, res.err_code);
          fail_count++;
        end else begin
          want = decoded_due.pop_front();
          check_field("out_kind", 8'(want.out_kind), 8'(res.out_kind));
          check_field("out_byte", want.out_byte, res.out_byte);
          check_field("err_code", 8'(want.err_code), 8'(res.err_code));
          check_field("last", 8'(want.last), 8'(res.last));
        end
      end
    end
  end

  initial begin
    // directed: end and byte with no quote, control byte, byte extremes,
    // a simple escape, a surrogate pair, and end inside a string
    put_end();
    put_byte(8'h00);
    put_byte(CH_QUOTE);
    put_byte(CTRL_MAX);
    put_byte(CH_QUOTE);
    put_byte(8'h20);
    put_byte(8'hFF);
    put_byte(CH_BSLASH);
    put_byte(8'h74);
    put_uescape(16'hD83D);
    put_uescape(16'hDE00);
    put_byte(CH_QUOTE);
    put_byte(CH_QUOTE);
    put_end();

    // random: mostly well-formed strings, some stray bytes and end marks
    while (text_backlog.size() < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 2) == 0) put_end();
        else put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_string();
      end
    end
    // let the block run dry twice along the way
    text_backlog[200].drain = 1'b1;
    text_backlog[380].drain = 1'b1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_backlog.size() != 0 || text_valid) @(negedge clk);
    while (decoded_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
dv/tb_json_string_unescape_utf8.sv
